/* rtl/core/lxfr_pkg.sv */
// ----------------------------------------------------------------------------
// lxfr_pkg
// Shared constants and types for the length-prefixed XOR frame receiver.
// ----------------------------------------------------------------------------
package lxfr_pkg;

  localparam int BYTE_W           = 8;
  localparam int POS_W            = 6;
  localparam int LENGTH_INDEX     = 3;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int MAX_PAYLOAD_DEF  = 32;
  localparam int QUEUE_DEPTH      = 2;

  // Back-end replay sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } bstate_t;

  // Bank handed back by the replay side once its frame is fully emitted
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

endpackage

/* rtl/core/lxfr_ram.sv */
// ----------------------------------------------------------------------------
// lxfr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lxfr_queue.sv */
// ----------------------------------------------------------------------------
// lxfr_queue
// Small FIFO carrying verified-frame requests from the front to the back.
// ----------------------------------------------------------------------------
module lxfr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = lxfr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/lxfr_front.sv */
// ----------------------------------------------------------------------------
// lxfr_front
// Receive side: store bytes into the current bank, track length and XOR,
// and queue a replay request when the checksum matches.
// ----------------------------------------------------------------------------
module lxfr_front #(
  parameter int HEADER_BYTES = lxfr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = lxfr_pkg::MAX_PAYLOAD_DEF,
  localparam int STORE_DEPTH = HEADER_BYTES + MAX_PAYLOAD,
  localparam int IDX_W       = $clog2(STORE_DEPTH),
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1),
  localparam int CMD_W       = 1 + CNT_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lxfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                       wr_en,
  output logic [IDX_W:0]             wr_addr,
  output logic [lxfr_pkg::BYTE_W-1:0] wr_data,
  output logic                       push,
  output logic [CMD_W-1:0]           push_data,
  input  lxfr_pkg::bank_free_t       bank_free
);

  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            body;
  logic [lxfr_pkg::BYTE_W-1:0] xsum;
  logic                        wbank;
  logic [1:0]                  busy;

  logic                        take;
  logic [CNT_W-1:0]            body_now;
  logic                        in_body;
  logic                        is_len;
  logic                        too_long;

  assign in_stall = busy[wbank];
  assign take     = in_valid && !in_stall;
  assign body_now = (cnt < CNT_W'(HEADER_BYTES)) ? CNT_W'(HEADER_BYTES) : body;
  assign in_body  = (cnt < body_now);
  assign is_len   = (cnt == CNT_W'(lxfr_pkg::LENGTH_INDEX));
  assign too_long = (rx_byte > lxfr_pkg::BYTE_W'(MAX_PAYLOAD));

  assign wr_en     = take && in_body;
  assign wr_addr   = {wbank, cnt[IDX_W-1:0]};
  assign wr_data   = rx_byte;
  assign push      = take && !in_body && (rx_byte == xsum);
  assign push_data = {wbank, body_now};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      body  <= CNT_W'(HEADER_BYTES);
      xsum  <= '0;
      wbank <= 1'b0;
      busy  <= '0;
    end else begin
      if (bank_free.valid) begin
        busy[bank_free.bank] <= 1'b0;
      end
      if (take) begin
        if (in_body) begin
          if (is_len && too_long) begin
            // oversized length: drop the frame at once
            cnt  <= '0;
            xsum <= '0;
          end else begin
            cnt  <= cnt + CNT_W'(1);
            xsum <= xsum ^ rx_byte;
          end
          if (is_len) begin
            body <= CNT_W'(HEADER_BYTES) + CNT_W'(rx_byte);
          end
        end else begin
          // checksum byte: hand the bank over on a match, restart either way
          cnt  <= '0;
          xsum <= '0;
          if (rx_byte == xsum) begin
            busy[wbank] <= 1'b1;
            wbank       <= ~wbank;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/lxfr_back.sv */
// ----------------------------------------------------------------------------
// lxfr_back
// Replay side: pop a verified frame request and emit its stored bytes.
// ----------------------------------------------------------------------------
module lxfr_back #(
  parameter int HEADER_BYTES = lxfr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = lxfr_pkg::MAX_PAYLOAD_DEF,
  localparam int STORE_DEPTH = HEADER_BYTES + MAX_PAYLOAD,
  localparam int IDX_W       = $clog2(STORE_DEPTH),
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1),
  localparam int CMD_W       = 1 + CNT_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  logic [CMD_W-1:0]            q_data,
  output logic                        q_pop,
  output logic                        rd_en,
  output logic [IDX_W:0]              rd_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lxfr_pkg::POS_W-1:0]  byte_position,
  output logic                        last_of_frame,
  output lxfr_pkg::bank_free_t        bank_free
);

  lxfr_pkg::bstate_t state, state_next;
  logic              bank, bank_next;
  logic [CNT_W-1:0]  body, body_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic              is_last;

  assign is_last       = ((CNT_W'(idx) + CNT_W'(1)) == body);
  assign rd_addr       = {bank, idx};
  assign byte_position = lxfr_pkg::POS_W'(idx);
  assign last_of_frame = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lxfr_pkg::B_IDLE;
      bank  <= 1'b0;
      body  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      bank  <= bank_next;
      body  <= body_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    bank_next      = bank;
    body_next      = body;
    idx_next       = idx;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    out_valid      = 1'b0;
    bank_free      = '0;
    case (state)
      lxfr_pkg::B_IDLE: begin
        if (q_not_empty) begin
          q_pop      = 1'b1;
          bank_next  = q_data[CMD_W-1];
          body_next  = q_data[CNT_W-1:0];
          idx_next   = '0;
          state_next = lxfr_pkg::B_READ;
        end
      end
      lxfr_pkg::B_READ: begin
        rd_en      = 1'b1;
        state_next = lxfr_pkg::B_SHOW;
      end
      lxfr_pkg::B_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (is_last) begin
            bank_free.valid = 1'b1;
            bank_free.bank  = bank;
            state_next      = lxfr_pkg::B_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = lxfr_pkg::B_READ;
          end
        end
      end
      default: begin
        state_next = lxfr_pkg::B_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/length_xor_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// length_xor_frame_receiver_core
// Length-prefixed frame receiver with XOR checksum and stored-frame replay.
// ----------------------------------------------------------------------------
// Bytes enter on rx_byte at up to one per clock. A frame is HEADER_BYTES
// header bytes (header byte 3 is the payload length), that many payload
// bytes, then one checksum byte equal to the XOR of all header and payload
// bytes. A good frame is replayed on frame_byte with its byte_position and
// last_of_frame on the final byte; a bad checksum drops the frame silently,
// and a length above MAX_PAYLOAD drops it as soon as the length byte
// arrives. The frame store has two banks: the receive side fills one while
// the replay side drains the other, so input is stalled only when both
// banks hold verified frames that are not yet fully emitted. Replay reads
// each stored byte from the RAM, then shows it on the output and holds it
// while out_stall is high, so the next byte is read only once it is taken.
// The store needs no clearing after reset; no item is held off by reset.
// ----------------------------------------------------------------------------
module length_xor_frame_receiver_core #(
  parameter int HEADER_BYTES = lxfr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = lxfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // receive byte channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lxfr_pkg::BYTE_W-1:0] rx_byte,
  // verified frame byte channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lxfr_pkg::BYTE_W-1:0] frame_byte,
  output logic [lxfr_pkg::POS_W-1:0]  byte_position,
  output logic                        last_of_frame
);

  localparam int STORE_DEPTH = HEADER_BYTES + MAX_PAYLOAD;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int CMD_W       = 1 + CNT_W;
  // two banks, each addressed by a full index range
  localparam int RAM_DEPTH   = 2 ** (IDX_W + 1);

  // receive side -> frame store
  logic                        wr_en;
  logic [IDX_W:0]              wr_addr;
  logic [lxfr_pkg::BYTE_W-1:0] wr_data;
  // replay side -> frame store
  logic                        rd_en;
  logic [IDX_W:0]              rd_addr;
  // request queue: bank and frame length of each verified frame
  logic                        push;
  logic [CMD_W-1:0]            push_data;
  logic                        q_pop;
  logic                        q_not_empty;
  logic [CMD_W-1:0]            q_data;
  // bank released by the replay side
  lxfr_pkg::bank_free_t        bank_free;

  // Accept, store and check incoming bytes
  lxfr_front #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_data (push_data),
    .bank_free (bank_free)
  );

  // Hold verified-frame requests until the replay side is free
  lxfr_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // Double-banked frame store; read data holds while the output stalls
  lxfr_ram #(
    .WIDTH (lxfr_pkg::BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (frame_byte)
  );

  // Replay verified frames byte by byte
  lxfr_back #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_position (byte_position),
    .last_of_frame (last_of_frame),
    .bank_free     (bank_free)
  );

endmodule

/* sim/lxfr_frame_checker.sv */
// ----------------------------------------------------------------------------
// lxfr_frame_checker
// Watches both channels of the frame receiver, predicts the replayed bytes
// and compares every accepted output byte against the oldest prediction.
// ----------------------------------------------------------------------------
module lxfr_frame_checker #(
  parameter int HEADER_BYTES = lxfr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = lxfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [lxfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [lxfr_pkg::BYTE_W-1:0] frame_byte,
  input  logic [lxfr_pkg::POS_W-1:0]  byte_position,
  input  logic                        last_of_frame,
  output int unsigned                 mismatch_count,
  output int unsigned                 pending_bytes
);

  localparam int STORE_DEPTH = HEADER_BYTES + MAX_PAYLOAD;

  typedef struct {
    logic [lxfr_pkg::BYTE_W-1:0] data;
    logic [lxfr_pkg::POS_W-1:0]  pos;
    logic                        last;
  } replay_byte_t;

  replay_byte_t                replay_q[$];
  replay_byte_t                oldest;
  logic [lxfr_pkg::POS_W-1:0]  rx_count;
  logic [lxfr_pkg::BYTE_W-1:0] rx_xor;
  logic [lxfr_pkg::BYTE_W-1:0] rx_length;
  logic [lxfr_pkg::BYTE_W-1:0] frame_copy [STORE_DEPTH];
  int unsigned                 errors = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  // Follow one received byte through the framing rules; queue the replay of
  // a frame whose checksum matches.
  task automatic take_rx_byte(input logic [lxfr_pkg::BYTE_W-1:0] b);
    int                         body;
    replay_byte_t               entry;
    logic [lxfr_pkg::POS_W-1:0] pos_val;
    if (rx_count < HEADER_BYTES) body = HEADER_BYTES;
    else body = HEADER_BYTES + rx_length;
    if (rx_count < body) begin
      frame_copy[rx_count] = b;
      rx_xor = rx_xor ^ b;
      if (rx_count == lxfr_pkg::LENGTH_INDEX && b > MAX_PAYLOAD) begin
        // oversize length: drop the frame right away
        rx_length = b;
        rx_count  = '0;
        rx_xor    = '0;
      end else begin
        if (rx_count == lxfr_pkg::LENGTH_INDEX) rx_length = b;
        rx_count = rx_count + 1'b1;
      end
    end else begin
      if (b == rx_xor) begin
        for (int i = 0; i < body; i++) begin
          pos_val    = lxfr_pkg::POS_W'(i);
          entry.data = frame_copy[i];
          entry.pos  = pos_val;
          entry.last = (i == body - 1);
          replay_q.push_back(entry);
        end
      end
      rx_count = '0;
      rx_xor   = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_count  = '0;
      rx_xor    = '0;
      rx_length = '0;
      replay_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replay_q.size() == 0) begin
          report_mismatch("unexpected frame_byte", int'(frame_byte), -1);
        end else begin
          oldest = replay_q.pop_front();
          if (frame_byte !== oldest.data)
            report_mismatch("frame_byte", int'(frame_byte), int'(oldest.data));
          if (byte_position !== oldest.pos)
            report_mismatch("byte_position", int'(byte_position), int'(oldest.pos));
          if (last_of_frame !== oldest.last)
            report_mismatch("last_of_frame", int'(last_of_frame), int'(oldest.last));
        end
      end
      if (in_valid && !in_stall) take_rx_byte(rx_byte);
    end
    mismatch_count <= errors;
    pending_bytes  <= replay_q.size();
  end

endmodule

/* sim/length_xor_frame_receiver_core_tb.sv */
// ----------------------------------------------------------------------------
// length_xor_frame_receiver_core_tb
// Byte-stream stimulus and verdict for the length-prefixed XOR frame receiver.
// ----------------------------------------------------------------------------
// Feeds framed byte streams into the receiver: a short directed set (zero
// length, bad checksum, oversize length, extreme byte values), a pause that
// lets every pending replay drain, then random frames, mostly well formed
// with random content, mixed with bad checksums, oversize lengths and stray
// bytes. Both sides idle in random bursts except in the final stretch. The
// checker beside the block predicts and compares; this module only drives
// input bytes and output stalls and prints the verdict.
// ----------------------------------------------------------------------------
module length_xor_frame_receiver_core_tb;

  localparam int HDR          = lxfr_pkg::HEADER_BYTES_DEF;
  localparam int MAX_LEN      = lxfr_pkg::MAX_PAYLOAD_DEF;
  localparam int RANDOM_BYTES = 280;
  localparam int QUIET_AFTER  = 235;
  // extra wait after the drain, sized from the longest stored frame
  localparam int DRAIN_CYCLES = 2 * (HDR + MAX_LEN) + 30;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_OVERSIZE
  } frame_kind_t;

  logic                        clk;
  logic                        rst           = 1'b1;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [lxfr_pkg::BYTE_W-1:0] rx_byte       = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [lxfr_pkg::BYTE_W-1:0] frame_byte;
  logic [lxfr_pkg::POS_W-1:0]  byte_position;
  logic                        last_of_frame;

  int unsigned mismatch_count;
  int unsigned pending_bytes;
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;   // set for the final stretch: no idling

  length_xor_frame_receiver_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_of_frame (last_of_frame)
  );

  lxfr_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_byte     (frame_byte),
    .byte_position  (byte_position),
    .last_of_frame  (last_of_frame),
    .mismatch_count (mismatch_count),
    .pending_bytes  (pending_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: count cycles and end the run if the limit is reached.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Output side: stall in random bursts; drop to no stall in the quiet part.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one byte and hold it until the block takes it. The stall sampled
  // at the edge is the one the handshake used, so the check is race free.
  // Valid stays high into the next request unless an idle burst follows.
  task automatic push_byte(input logic [lxfr_pkg::BYTE_W-1:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Send a header (three free bytes then the length byte), the payload and
  // the checksum. An oversize frame stops after the length byte, since the
  // block drops it there.
  task automatic send_frame(input logic [lxfr_pkg::BYTE_W-1:0] h0,
                            input logic [lxfr_pkg::BYTE_W-1:0] h1,
                            input logic [lxfr_pkg::BYTE_W-1:0] h2,
                            input logic [lxfr_pkg::BYTE_W-1:0] length_byte,
                            input frame_kind_t               kind);
    logic [lxfr_pkg::BYTE_W-1:0] sum;
    logic [lxfr_pkg::BYTE_W-1:0] data;
    sum = h0 ^ h1 ^ h2 ^ length_byte;
    push_byte(h0);
    push_byte(h1);
    push_byte(h2);
    push_byte(length_byte);
    if (kind != FRAME_OVERSIZE) begin
      for (int i = 0; i < length_byte; i++) begin
        data = 8'($urandom_range(0, 255));
        sum  = sum ^ data;
        push_byte(data);
      end
      // a bad checksum flips at least one bit of the true XOR
      if (kind == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
      push_byte(sum);
    end
  endtask

  // Hold valid low and wait until the checker has nothing left pending.
  task automatic drain_replays();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned pick;
    int unsigned len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero length with extreme bytes, bad checksum, lengths just
    // and far above the limit, and a one-byte payload.
    send_frame(8'h00, 8'hFF, 8'h00, 8'd0, FRAME_GOOD);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'd0, FRAME_BAD_SUM);
    send_frame(8'h12, 8'h34, 8'h56, 8'(MAX_LEN + 1), FRAME_OVERSIZE);
    send_frame(8'h00, 8'h00, 8'h00, 8'hFF, FRAME_OVERSIZE);
    send_frame(8'hFF, 8'h00, 8'hFF, 8'd1, FRAME_GOOD);

    // Hold off the sender until every replay has come out.
    drain_replays();

    // Random: open with a full-length frame, then a mix weighted toward
    // well-formed frames so the replay path stays busy.
    random_start = sent_count;
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'(MAX_LEN), FRAME_GOOD);
    while (sent_count - random_start < RANDOM_BYTES) begin
      if (sent_count - random_start >= QUIET_AFTER) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN) : $urandom_range(0, 6);
      if (pick < 70) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'(len), FRAME_GOOD);
      end else if (pick < 82) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'(len), FRAME_BAD_SUM);
      end else if (pick < 92) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(MAX_LEN + 1, 255)),
                   FRAME_OVERSIZE);
      end else begin
        // stray bytes knock the framing out of step
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
    end

    drain_replays();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
